### hw/rtl/per_type_free_object_cache_core_macros.svh
// Assertion macros shared by the checker of the free-object cache.
`ifndef PER_TYPE_FREE_OBJECT_CACHE_CORE_MACROS_SVH
`define PER_TYPE_FREE_OBJECT_CACHE_CORE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PFOC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PFOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pfoc_pkg.sv
// Types and constants of the per-type free-object cache.
`default_nettype none
package pfoc_pkg;

    localparam int TYPE_ID_W = 4;
    localparam int HANDLE_W  = 32;
    localparam int PEAK_W    = 16;

    localparam logic [PEAK_W-1:0] RUN_MAX = {PEAK_W{1'b1}};

    // request command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request, start the per-type state read
        logic exec;      // update per-type state and the handle store
        logic load_out;  // move the result into the response register
    } t_ctl_cmd;

endpackage
`default_nettype wire

### hw/rtl/pfoc_if.sv
// Request and response channel interfaces of the free-object cache.
`default_nettype none
interface pfoc_req_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [pfoc_pkg::TYPE_ID_W-1:0] type_id;
    logic [pfoc_pkg::HANDLE_W-1:0]  handle_in;

    modport source (output valid, output command, output type_id, output handle_in,
                    input ready);
    modport sink   (input valid, input command, input type_id, input handle_in,
                    output ready);
endinterface

interface pfoc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          handle_valid;
    logic [pfoc_pkg::HANDLE_W-1:0] handle_out;
    logic [pfoc_pkg::PEAK_W-1:0]   peak_overflow;

    modport source (output valid, output handle_valid, output handle_out,
                    output peak_overflow, input ready);
    modport sink   (input valid, input handle_valid, input handle_out,
                    input peak_overflow, output ready);
endinterface
`default_nettype wire

### hw/rtl/pfoc_ctrl.sv
// Request sequencer of the free-object cache.
`default_nettype none
module pfoc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    input  wire logic               i_rsp_ready,
    output logic                    o_req_ready,
    output logic                    o_rsp_valid,
    output pfoc_pkg::t_ctl_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_req_ready;
    logic   r_rsp_valid;
    logic   load_out;

    assign load_out = (r_state == S_RESP) && (!r_rsp_valid || i_rsp_ready);

    assign o_cmd.capture  = i_req_valid && r_req_ready;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.load_out = load_out;
    assign o_req_ready    = r_req_ready;
    assign o_rsp_valid    = r_rsp_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_ready <= 1'b1;
            r_rsp_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_state     <= S_EXEC;
                        r_req_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (load_out) begin
                        r_state     <= S_IDLE;
                        r_req_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_req_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/pfoc_dpath.sv
// Per-type state memory, handle store and result register of the cache.
`default_nettype none
module pfoc_dpath #(
    parameter int SLOTS = 16,
    parameter int TYPES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire pfoc_pkg::t_ctl_cmd             i_cmd,
    input  wire logic                           i_command,
    input  wire logic [pfoc_pkg::TYPE_ID_W-1:0] i_type_id,
    input  wire logic [pfoc_pkg::HANDLE_W-1:0]  i_handle_in,
    output logic                                o_handle_valid,
    output logic [pfoc_pkg::HANDLE_W-1:0]       o_handle_out,
    output logic [pfoc_pkg::PEAK_W-1:0]         o_peak_overflow
);

    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int TIDX_W      = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int STORE_DEPTH = TYPES * (2 ** SLOT_W);
    localparam int PEAK_W      = pfoc_pkg::PEAK_W;
    localparam int HANDLE_W    = pfoc_pkg::HANDLE_W;

    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOTS_X  = (SLOT_W + 1)'(SLOTS);

    // per-type state, one word per type, valid bit per type
    logic [CNT_W-1:0]  r_cnt_mem  [TYPES];
    logic [SLOT_W-1:0] r_old_mem  [TYPES];
    logic [PEAK_W-1:0] r_run_mem  [TYPES];
    logic [PEAK_W-1:0] r_peak_mem [TYPES];
    logic [TYPES-1:0]  r_meta_vld;

    logic [HANDLE_W-1:0] r_store [STORE_DEPTH];

    // latched request and registered reads
    logic                r_command;
    logic [TIDX_W-1:0]   r_tidx;
    logic                r_in_range;
    logic [HANDLE_W-1:0] r_handle_in;
    logic                r_meta_hit;
    logic [CNT_W-1:0]    r_rd_cnt;
    logic [SLOT_W-1:0]   r_rd_old;
    logic [PEAK_W-1:0]   r_rd_run;
    logic [PEAK_W-1:0]   r_rd_peak;
    logic [HANDLE_W-1:0] r_store_rd;
    logic                r_res_valid;
    logic [PEAK_W-1:0]   r_res_peak;
    logic                r_handle_valid;
    logic [HANDLE_W-1:0] r_handle_out;
    logic [PEAK_W-1:0]   r_peak_out;

    logic [TIDX_W-1:0]   tidx_in;
    logic [CNT_W-1:0]    cnt;
    logic [SLOT_W-1:0]   old;
    logic [PEAK_W-1:0]   run;
    logic [PEAK_W-1:0]   peak;
    logic [CNT_W-1:0]    offset;
    logic [SLOT_W:0]     pos_sum;
    logic [SLOT_W-1:0]   pos;
    logic [TIDX_W+SLOT_W-1:0] store_addr;
    logic                store_we;
    logic [CNT_W-1:0]    n_cnt;
    logic [SLOT_W-1:0]   n_old;
    logic [PEAK_W-1:0]   n_run;
    logic [PEAK_W-1:0]   n_peak;
    logic                n_res_valid;

    assign tidx_in = TIDX_W'(i_type_id);

    // unwritten type state reads as zero
    assign cnt  = r_meta_hit ? r_rd_cnt  : '0;
    assign old  = r_meta_hit ? r_rd_old  : '0;
    assign run  = r_meta_hit ? r_rd_run  : '0;
    assign peak = r_meta_hit ? r_rd_peak : '0;

    // newest+1 for push (wraps onto oldest when full), newest for query
    assign offset  = (r_command == pfoc_pkg::CMD_QUERY) ? cnt - CNT_W'(1) : cnt;
    assign pos_sum = {1'b0, old} + (SLOT_W + 1)'(offset);
    assign pos     = (pos_sum >= SLOTS_X) ? SLOT_W'(pos_sum - SLOTS_X) : SLOT_W'(pos_sum);
    assign store_addr = {r_tidx, pos};

    always_comb begin
        n_cnt       = cnt;
        n_old       = old;
        n_run       = run;
        n_peak      = peak;
        n_res_valid = 1'b0;
        store_we    = 1'b0;
        if (r_in_range) begin
            if (r_command == pfoc_pkg::CMD_PUSH) begin
                store_we = 1'b1;
                if (cnt == CNT_FULL) begin
                    n_res_valid = 1'b1;
                    n_old       = (old == SLOT_TOP) ? '0 : old + SLOT_W'(1);
                    if (run != pfoc_pkg::RUN_MAX) begin
                        n_run = run + PEAK_W'(1);
                    end
                end else begin
                    n_cnt = cnt + CNT_W'(1);
                end
            end else if (cnt != '0) begin
                n_res_valid = 1'b1;
                n_peak      = (run > peak) ? run : peak;
                n_run       = '0;
                n_cnt       = cnt - CNT_W'(1);
            end
        end
    end

    // request latch, per-type state read and state write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command   <= i_command;
            r_tidx      <= tidx_in;
            r_in_range  <= (32'(i_type_id) < 32'(TYPES));
            r_handle_in <= i_handle_in;
            r_meta_hit  <= r_meta_vld[tidx_in];
            r_rd_cnt    <= r_cnt_mem[tidx_in];
            r_rd_old    <= r_old_mem[tidx_in];
            r_rd_run    <= r_run_mem[tidx_in];
            r_rd_peak   <= r_peak_mem[tidx_in];
        end
        if (i_cmd.exec && r_in_range) begin
            r_cnt_mem[r_tidx]  <= n_cnt;
            r_old_mem[r_tidx]  <= n_old;
            r_run_mem[r_tidx]  <= n_run;
            r_peak_mem[r_tidx] <= n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
        end else if (i_cmd.exec && r_in_range) begin
            r_meta_vld[r_tidx] <= 1'b1;
        end
    end

    // handle store: read returns the old entry on an evicting push
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_store_rd <= r_store[store_addr];
            if (store_we) begin
                r_store[store_addr] <= r_handle_in;
            end
            r_res_valid <= n_res_valid;
            r_res_peak  <= r_in_range ? n_peak : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_handle_valid <= r_res_valid;
            r_handle_out   <= r_res_valid ? r_store_rd : '0;
            r_peak_out     <= r_res_peak;
        end
    end

    assign o_handle_valid  = r_handle_valid;
    assign o_handle_out    = r_handle_out;
    assign o_peak_overflow = r_peak_out;

endmodule
`default_nettype wire

### hw/rtl/per_type_free_object_cache_core.sv
// An accepted request passes the update (S_EXEC) and respond (S_RESP) states before its
// response is valid, longer while the output stalls. One request is in work at a time, set
// by the capture / update / respond sequence around the single-port per-type state memory
// and the handle store; the next is taken while the previous response waits in its register.
// Reset (i_rst_n low, synchronous) empties every type's stack and clears its counters;
// the handle store itself is not cleared and needs no clearing pass.
`default_nettype none
module per_type_free_object_cache_core #(
    parameter int SLOTS = 16,  // cached handles per type, 2..256
    parameter int TYPES = 16   // object types, 1..16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfoc_req_if.sink   i_req,
    pfoc_rsp_if.source o_rsp
);

    // Control flow:
    //   capture  - request latched, per-type state word read (count, oldest, run, peak)
    //   update   - stack position computed, handle store read/written, state written back
    //   respond  - evicted or popped handle moved into the response register
    // Each type's stack is circular; the oldest pointer moves on an evicting push.
    pfoc_pkg::t_ctl_cmd ctl_cmd;

    pfoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (ctl_cmd)
    );

    // Datapath holds all storage; a type id of TYPES or more gives an empty result
    // with zero peak and touches nothing.
    pfoc_dpath #(
        .SLOTS (SLOTS),
        .TYPES (TYPES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .i_command       (i_req.command),
        .i_type_id       (i_req.type_id),
        .i_handle_in     (i_req.handle_in),
        .o_handle_valid  (o_rsp.handle_valid),
        .o_handle_out    (o_rsp.handle_out),
        .o_peak_overflow (o_rsp.peak_overflow)
    );

endmodule
`default_nettype wire

### hw/rtl/pfoc_chk.sv
// Port-level checker of the free-object cache and its bind.
`default_nettype none
`include "per_type_free_object_cache_core_macros.svh"
module pfoc_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic                          i_handle_valid,
    input wire logic [pfoc_pkg::HANDLE_W-1:0] i_handle_out,
    input wire logic [pfoc_pkg::PEAK_W-1:0]   i_peak_overflow
);

    `PFOC_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_handle_out) && $stable(i_peak_overflow), "stalled response changed")
    `PFOC_ASSERT_NEXT(a_one_request, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")
    `PFOC_ASSERT_SAME(a_rsp_after_work, $rose(i_rsp_valid), $past(!i_req_ready), "response without work")
    `PFOC_ASSERT_SAME(a_null_handle, i_rsp_valid && !i_handle_valid, i_handle_out == '0, "null handle not zero")

endmodule

bind per_type_free_object_cache_core pfoc_chk u_pfoc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_handle_valid  (o_rsp.handle_valid),
    .i_handle_out    (o_rsp.handle_out),
    .i_peak_overflow (o_rsp.peak_overflow)
);
`default_nettype wire

### tb/tb_per_type_free_object_cache_core.sv
// Self-checking testbench for the per-type free-object cache core.
`default_nettype none
module tb_per_type_free_object_cache_core;

    localparam int TYPE_ID_W = pfoc_pkg::TYPE_ID_W;
    localparam int HANDLE_W  = pfoc_pkg::HANDLE_W;
    localparam int PEAK_W    = pfoc_pkg::PEAK_W;
    localparam logic CMD_PUSH  = pfoc_pkg::CMD_PUSH;
    localparam logic CMD_QUERY = pfoc_pkg::CMD_QUERY;
    localparam logic [PEAK_W-1:0] RUN_MAX = pfoc_pkg::RUN_MAX;

    // Block configuration under test; the predictor uses the same sizes.
    localparam int N_SLOTS = 16;
    localparam int N_TYPES = 16;

    // Nominal delay from request accept until its response can be taken.
    localparam int LATENCY = 3;
    // Settling time after the last expected response before the verdict.
    localparam int TAIL_CYCLES = 4 * LATENCY;
    // Long receiver hold-off; must stay well under the watchdog limit.
    localparam int RSP_HOLD_CYCLES = 400;
    // Cycles without any accepted request or response before giving up.
    // Worst silent stretch is the hold-off above or a pair of the longest stalls.
    localparam int WATCHDOG_LIMIT = 5 * RSP_HOLD_CYCLES;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int PHASE_REQUESTS = 100;

    // One response as the core should return it.
    typedef struct packed {
        logic                handle_valid;
        logic [HANDLE_W-1:0] handle_out;
        logic [PEAK_W-1:0]   peak_overflow;
    } t_cache_result;

    logic clk;
    logic rst_n;

    pfoc_req_if req_ch ();
    pfoc_rsp_if rsp_ch ();

    per_type_free_object_cache_core #(
        .SLOTS(N_SLOTS),
        .TYPES(N_TYPES)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // ------------------------------------------------------------------
    // Predicted cache contents: one circular stack per type, plus the
    // overflow run and peak counters. Slot memory is only read at live
    // positions, so its initial contents never matter.
    // ------------------------------------------------------------------
    logic [HANDLE_W-1:0] slot_mem    [N_TYPES][N_SLOTS];
    logic [4:0]          stack_depth [N_TYPES];
    logic [3:0]          oldest_pos  [N_TYPES];
    logic [PEAK_W-1:0]   run_len     [N_TYPES];
    logic [PEAK_W-1:0]   peak_len    [N_TYPES];

    // Responses still owed by the core, oldest first.
    t_cache_result pending_results[$];

    int mismatch_count = 0;
    int checked_count  = 0;
    int push_count     = 0;
    int evict_count    = 0;
    int query_count    = 0;
    int pop_count      = 0;
    int empty_count    = 0;
    int idle_cycles    = 0;

    // Traffic shaping knobs, set by the test tasks.
    bit full_rate    = 1'b0;   // no gaps on either side
    bit hold_request = 1'b0;   // ask the receiver for one long hold-off
    int hold_left    = 0;
    int stall_left   = 0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: applies one accepted request to the shadow state and
    // returns the response the core must produce for it.
    // ------------------------------------------------------------------
    function automatic t_cache_result predict_cache_access(
        input logic                cmd,
        input logic [TYPE_ID_W-1:0] tid,
        input logic [HANDLE_W-1:0] handle
    );
        t_cache_result res;
        int            depth;
        int            pos;
        res = '0;
        depth = int'(stack_depth[tid]);
        if (cmd == CMD_PUSH) begin
            push_count++;
            if (depth >= N_SLOTS) begin
                // Full: overwrite the oldest entry and hand it back.
                pos = int'(oldest_pos[tid]);
                res.handle_valid = 1'b1;
                res.handle_out = slot_mem[tid][pos];
                slot_mem[tid][pos] = handle;
                oldest_pos[tid] = 4'((pos + 1) % N_SLOTS);
                if (run_len[tid] != RUN_MAX)
                    run_len[tid] = run_len[tid] + PEAK_W'(1);
                evict_count++;
            end else begin
                pos = (int'(oldest_pos[tid]) + depth) % N_SLOTS;
                slot_mem[tid][pos] = handle;
                stack_depth[tid] = 5'(depth + 1);
            end
        end else begin
            query_count++;
            if (depth > 0) begin
                // Pop the newest; peak absorbs the run, which then restarts.
                if (run_len[tid] > peak_len[tid])
                    peak_len[tid] = run_len[tid];
                run_len[tid] = '0;
                depth = depth - 1;
                stack_depth[tid] = 5'(depth);
                pos = (int'(oldest_pos[tid]) + depth) % N_SLOTS;
                res.handle_valid = 1'b1;
                res.handle_out = slot_mem[tid][pos];
                pop_count++;
            end else begin
                // Empty stack: null handle, counters untouched.
                empty_count++;
            end
        end
        res.peak_overflow = peak_len[tid];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [HANDLE_W-1:0] got,
                                   input logic [HANDLE_W-1:0] want);
        mismatch_count++;
        $display("mismatch on %s: got %h, expected %h (response %0d)",
                 field, got, want, checked_count);
    endtask

    // ------------------------------------------------------------------
    // Monitor: predicts each accepted request and checks each accepted
    // response against the oldest prediction. Values sampled here are the
    // ones present just before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_cache_result want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected response, handle_out", rsp_ch.handle_out, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.handle_valid !== want.handle_valid)
                        report_mismatch("handle_valid", HANDLE_W'(rsp_ch.handle_valid),
                                        HANDLE_W'(want.handle_valid));
                    if (rsp_ch.handle_out !== want.handle_out)
                        report_mismatch("handle_out", rsp_ch.handle_out, want.handle_out);
                    if (rsp_ch.peak_overflow !== want.peak_overflow)
                        report_mismatch("peak_overflow", HANDLE_W'(rsp_ch.peak_overflow),
                                        HANDLE_W'(want.peak_overflow));
                end
                checked_count++;
            end
            if (req_ch.valid && req_ch.ready)
                pending_results.push_back(predict_cache_access(req_ch.command,
                                                               req_ch.type_id,
                                                               req_ch.handle_in));
        end
    end

    // Watchdog: a stretch with no handshake on either side means a hang.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("timeout: no handshake for %0d cycles, %0d responses owed",
                             idle_cycles, pending_results.size());
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70)
            return int'($urandom_range(1, 3));
        else if (r < 95)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic int sender_gap();
        if (full_rate || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request, counted
    // here so the sender keeps offering meanwhile.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_request) begin
            hold_left = RSP_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!full_rate && $urandom_range(0, 99) < 25) begin
            stall_left = idle_len() - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Valid is only lowered when a gap follows, so back-to-back
    // requests keep it high with a single assignment per edge. Returns at
    // the edge where the request is taken.
    // ------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [TYPE_ID_W-1:0] tid,
                                input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.type_id   <= tid;
        req_ch.handle_in <= handle;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // Must be followed by time passing before the next request.
    task automatic stop_sending();
        req_ch.valid <= 1'b0;
    endtask

    // Always waits for a clock edge before checking, so a prior stop cannot collide
    // with the next raise of valid.
    task automatic wait_drained();
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    function automatic logic [HANDLE_W-1:0] random_handle();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 5)
            return '0;
        else if (r < 10)
            return '1;
        return HANDLE_W'($urandom());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge types, the zero and all-ones handles, queries on empty stacks,
    // filling a stack, eviction of the oldest, and the peak update on pop.
    task automatic test_directed();
        send_request(CMD_PUSH, 4'd0, '0);
        send_request(CMD_QUERY, 4'd0, '1);     // zero handle comes back valid
        send_request(CMD_QUERY, 4'd0, '0);     // now empty
        send_request(CMD_QUERY, 4'd15, '0);    // never pushed
        send_request(CMD_PUSH, 4'd15, '1);
        for (int i = 1; i < N_SLOTS; i++)
            send_request(CMD_PUSH, 4'd15, 32'h1500_0000 + i);
        send_request(CMD_PUSH, 4'd15, 32'hA5A5_A5A5);   // evicts all-ones
        send_request(CMD_PUSH, 4'd15, 32'h5A5A_5A5A);   // evicts the next oldest
        send_request(CMD_QUERY, 4'd15, '0);    // peak picks up a run of two
        send_request(CMD_QUERY, 4'd15, '0);    // run cleared, peak holds
        stop_sending();
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while requests keep coming,
    // so the core fills and stalls its input.
    task automatic test_backpressure();
        full_rate = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(1'($urandom_range(0, 1)),
                         TYPE_ID_W'($urandom_range(0, N_TYPES - 1)),
                         random_handle());
        full_rate = 1'b0;
        stop_sending();
        // Sender pauses until everything owed has come back.
        wait_drained();
    endtask

    // Random phases, each with its own push/query mix and a narrow or wide
    // set of types, so stacks fill, overflow and drain repeatedly.
    task automatic test_random();
        int push_pct;
        int type_base;
        int type_span;
        logic cmd;
        for (int phase = 0; phase < RANDOM_REQUESTS / PHASE_REQUESTS; phase++) begin
            push_pct  = int'($urandom_range(20, 85));
            type_base = int'($urandom_range(0, N_TYPES - 1));
            case ($urandom_range(0, 3))
                0: type_span = 1;
                1: type_span = 2;
                2: type_span = 4;
                default: type_span = N_TYPES;
            endcase
            full_rate = (phase % 4 == 3);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_QUERY;
                send_request(cmd,
                             TYPE_ID_W'(type_base + int'($urandom_range(0, type_span - 1))),
                             random_handle());
            end
        end
        full_rate = 1'b0;
        stop_sending();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_PUSH;
        req_ch.type_id = '0;
        req_ch.handle_in = '0;
        rsp_ch.ready = 1'b0;
        for (int t = 0; t < N_TYPES; t++) begin
            stack_depth[t] = '0;
            oldest_pos[t]  = '0;
            run_len[t]     = '0;
            peak_len[t]    = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("responses never returned", HANDLE_W'(pending_results.size()), '0);

        $display("covered %0d pushes with %0d evictions and %0d queries with %0d pops",
                 push_count, evict_count, query_count, pop_count);
        $display("%0d queries hit empty stacks; %0d responses checked, %0d mismatches",
                 empty_count, checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/pfoc_pkg.sv
hw/rtl/pfoc_if.sv
hw/rtl/pfoc_ctrl.sv
hw/rtl/pfoc_dpath.sv
hw/rtl/per_type_free_object_cache_core.sv
hw/rtl/pfoc_chk.sv
tb/tb_per_type_free_object_cache_core.sv
